### design/circular_fifo_queue_assert.svh
// assertion macros used by the port checker
`ifndef CIRCULAR_FIFO_QUEUE_ASSERT_SVH
`define CIRCULAR_FIFO_QUEUE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CFQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/cfq_pkg.sv
// types and constants of the circular fifo queue
package cfq_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_DISP = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic exec;
		logic emit;
		logic pop;
		logic step;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic res_ok;
		logic last_res;
		logic out_free;
	} sts_t;

endpackage

### design/cfq_ctrl.sv
// controller state machine of the circular fifo queue
module cfq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  cfq_pkg::sts_t sts,
	output cfq_pkg::cmd_t cmd
);

	cfq_pkg::state_t state_q;
	cfq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			cfq_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = cfq_pkg::S_EXEC;
				end
			end
			cfq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = cfq_pkg::S_EMIT;
			end
			cfq_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last_res) begin
						cmd.pop = (sts.op == cfq_pkg::OP_DEQ) && sts.res_ok;
						state_d = cfq_pkg::S_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_d  = cfq_pkg::S_EXEC;
					end
				end
			end
			default: begin
				state_d = cfq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### design/cfq_dp.sv
// datapath of the circular fifo queue: slot memory, pointers, output register
module cfq_dp #(
	parameter int DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cfq_pkg::cmd_t                     cmd,
	output cfq_pkg::sts_t                     sts,
	input  logic [1:0]                        opcode,
	input  logic signed [cfq_pkg::DATA_W-1:0] push_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [cfq_pkg::DATA_W-1:0] out_value,
	output logic                              last
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	logic signed [cfq_pkg::DATA_W-1:0] mem [DEPTH];

	logic [PTR_W-1:0]                  head_q;
	logic [PTR_W-1:0]                  tail_q;
	logic [PTR_W-1:0]                  walk_q;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  rem_q;
	cfq_pkg::op_t                      op_q;
	logic signed [cfq_pkg::DATA_W-1:0] val_q;
	logic signed [cfq_pkg::DATA_W-1:0] rd_q;
	logic [1:0]                        res_status_q;
	logic                              out_valid_q;
	logic [1:0]                        status_q;
	logic signed [cfq_pkg::DATA_W-1:0] out_value_q;
	logic                              last_q;

	logic full;
	logic empty;
	logic do_write;
	logic res_ok;
	logic last_res;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
		adv = (p == PTR_MAX) ? '0 : p + PTR_W'(1);
	endfunction

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign do_write = cmd.exec && (op_q == cfq_pkg::OP_ENQ) && !full;
	assign res_ok   = (res_status_q == cfq_pkg::ST_OK);
	assign last_res = (op_q != cfq_pkg::OP_DISP) || !res_ok || (rem_q == CNT_ONE);

	assign sts.op       = op_q;
	assign sts.res_ok   = res_ok;
	assign sts.last_res = last_res;
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[tail_q] <= val_q;
		end
		if (cmd.exec) begin
			rd_q <= mem[walk_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= cfq_pkg::op_t'(opcode);
			val_q <= push_value;
		end
		if (cmd.exec) begin
			if (op_q == cfq_pkg::OP_ENQ) begin
				res_status_q <= full ? cfq_pkg::ST_FULL : cfq_pkg::ST_OK;
			end else begin
				res_status_q <= empty ? cfq_pkg::ST_EMPTY : cfq_pkg::ST_OK;
			end
		end
		if (cmd.emit) begin
			status_q    <= res_status_q;
			out_value_q <= (res_ok && (op_q != cfq_pkg::OP_ENQ)) ? rd_q : '0;
			last_q      <= last_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			walk_q  <= '0;
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			if (cmd.take) begin
				walk_q <= head_q;
				rem_q  <= count_q;
			end
			if (cmd.step) begin
				walk_q <= adv(walk_q);
				rem_q  <= rem_q - CNT_ONE;
			end
			if (do_write) begin
				tail_q  <= adv(tail_q);
				count_q <= count_q + CNT_ONE;
			end
			if (cmd.pop) begin
				head_q  <= adv(head_q);
				count_q <= count_q - CNT_ONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_value = out_value_q;
	assign last      = last_q;

endmodule

### design/circular_fifo_queue.sv
// top level of the circular fifo queue
// A FIFO of DEPTH signed 32-bit words, every slot usable.
// Input channel: in_valid / in_stall carries opcode and push_value;
//   enqueue, dequeue, peek or display of all stored words.
// Output channel: out_valid / out_stall carries status, out_value, last.
//   Each request gives one result; display gives one result per stored word,
//   head first, with last set on the final one. Errors give status full or
//   empty with out_value zero.
// Timing: a request is taken in the idle state only; its first result
//   passes the EXEC and EMIT states and is then loaded into the output
//   register. Display returns from EMIT to EXEC for each further word,
//   as the slot memory has a registered read port.
// The output register holds a result while out_stall is high; the block
//   then waits before loading the next result and takes no new request.
//   A new request is taken while the last result still waits in the
//   output register.
// Reset clears pointers, fill count and valid; the slot memory is not
//   cleared, and only data from written slots ever reaches out_value.
module circular_fifo_queue #(
	parameter int DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic signed [cfq_pkg::DATA_W-1:0] push_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [cfq_pkg::DATA_W-1:0] out_value,
	output logic                              last
);

	cfq_pkg::cmd_t cmd;
	cfq_pkg::sts_t sts;

	cfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (opcode),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_value  (out_value),
		.last       (last)
	);

endmodule

### design/cfq_checker.sv
// port checker of the circular fifo queue and its bind
`include "circular_fifo_queue_assert.svh"

module cfq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [1:0]                        status,
	input logic signed [cfq_pkg::DATA_W-1:0] out_value,
	input logic                              last
);

	`CFQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")
	`CFQ_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(status) && $stable(out_value) && $stable(last), "stalled result changed")
	`CFQ_ASSERT_NOW(a_err_zero, out_valid && (status != cfq_pkg::ST_OK), (out_value == '0) && last, "error result not zero or not last")
	`CFQ_ASSERT_NEXT(a_one_request, in_valid && !in_stall, in_stall, "request taken while busy")

endmodule

bind circular_fifo_queue cfq_checker u_cfq_checker (.*);
